// File: hw/rtl/rmq_pkg.sv
package rmq_pkg;

   // Branch taken by the four-case method
   typedef enum logic [1:0] {
      CASE_TRACE = 2'd0,
      CASE_X     = 2'd1,
      CASE_Y     = 2'd2,
      CASE_Z     = 2'd3
   } case_type;

endpackage

// File: hw/rtl/rmq_isqrt.sv
module rmq_isqrt
   import rmq_pkg::*;
#(
   parameter int NP = 16
) (
   input  logic              clock,
   input  logic [2*NP-1:0]   rad_in,
   output logic [NP-1:0]     root_out
);

   localparam int RB = NP + 2;

   logic [RB-1:0]   rem_in  [NP];
   logic [RB-1:0]   rem_ff  [NP];
   logic [NP-1:0]   root_in [NP];
   logic [NP-1:0]   root_ff [NP];
   logic [2*NP-1:0] rad_in_s [NP];
   logic [2*NP-1:0] rad_ff  [NP];

   // One root bit per stage: bring down two radicand bits, try 4q+1
   for (genvar k = 0; k < NP; k++) begin : g_step
      logic [RB-1:0]   rem_prev;
      logic [NP-1:0]   root_prev;
      logic [2*NP-1:0] rad_prev;
      logic [RB+1:0]   cat;
      logic [RB+1:0]   trial;
      logic            ge;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = rad_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
      end

      always_comb begin
         cat         = {rem_prev, rad_prev[2*NP-1 -: 2]};
         trial       = {2'b00, root_prev, 2'b01};
         ge          = cat >= trial;
         rem_in[k]   = ge ? RB'(cat - trial) : RB'(cat);
         root_in[k]  = {root_prev[NP-2:0], ge};
         rad_in_s[k] = {rad_prev[2*NP-3:0], 2'b00};
      end
   end

   // Advance all stages
   always_ff @(posedge clock) begin
      for (int k = 0; k < NP; k++) begin
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
         rad_ff[k]  <= rad_in_s[k];
      end
   end

   assign root_out = root_ff[NP-1];

endmodule

// File: hw/rtl/rmq_div.sv
module rmq_div
   import rmq_pkg::*;
#(
   parameter int NW  = 32,
   parameter int DVW = 17,
   parameter int QW  = 16
) (
   input  logic           clock,
   input  logic [NW-1:0]  num_in,
   input  logic [DVW-1:0] den_in,
   output logic [QW-1:0]  quo_out
);

   localparam int CW = ((NW > DVW + QW) ? NW : DVW + QW) + 1;

   logic [NW-1:0]  rem_in [QW];
   logic [NW-1:0]  rem_ff [QW];
   logic [QW-1:0]  quo_in [QW];
   logic [QW-1:0]  quo_ff [QW];
   logic [DVW-1:0] den_ff [QW];

   // Restoring division, one quotient bit per stage from the top
   for (genvar j = 0; j < QW; j++) begin : g_step
      logic [NW-1:0]  rem_prev;
      logic [QW-1:0]  quo_prev;
      logic [DVW-1:0] den_prev;
      logic [CW-1:0]  shifted;
      logic           ge;

      if (j == 0) begin : g_first
         assign rem_prev = num_in;
         assign quo_prev = '0;
         assign den_prev = den_in;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign quo_prev = quo_ff[j-1];
         assign den_prev = den_ff[j-1];
      end

      always_comb begin
         shifted   = CW'(den_prev) << (QW - 1 - j);
         ge        = CW'(rem_prev) >= shifted;
         rem_in[j] = ge ? NW'(CW'(rem_prev) - shifted) : rem_prev;
         quo_in[j] = {quo_prev[QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         den_ff[j] <= den_prev;
      end
   end

   // Advance remainder and quotient
   always_ff @(posedge clock) begin
      for (int j = 0; j < QW; j++) begin
         rem_ff[j] <= rem_in[j];
         quo_ff[j] <= quo_in[j];
      end
   end

   assign quo_out = quo_ff[QW-1];

endmodule

// File: hw/rtl/rotation_matrix_to_quaternion.sv
// The result strobe follows the accepting edge through the branch register, the root stages,
// the divide-setup register, the quotient stages and the output register.
// Throughput: one request per cycle; the root and the three quotients are bit-serial stages
// of a straight pipeline, one bit per stage, so busy stays low.
// Reset: synchronous, clears all stage valid bits; no result is lost to a stalled receiver
// since the receiver cannot stall.
module rotation_matrix_to_quaternion
   import rmq_pkg::*;
#(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [DATA_WIDTH-1:0] req_elem_r0c0,
   input  logic [DATA_WIDTH-1:0] req_elem_r0c1,
   input  logic [DATA_WIDTH-1:0] req_elem_r0c2,
   input  logic [DATA_WIDTH-1:0] req_elem_r1c0,
   input  logic [DATA_WIDTH-1:0] req_elem_r1c1,
   input  logic [DATA_WIDTH-1:0] req_elem_r1c2,
   input  logic [DATA_WIDTH-1:0] req_elem_r2c0,
   input  logic [DATA_WIDTH-1:0] req_elem_r2c1,
   input  logic [DATA_WIDTH-1:0] req_elem_r2c2,
   output logic                  rsp_strobe,
   output logic [DATA_WIDTH-1:0] rsp_quat_w,
   output logic [DATA_WIDTH-1:0] rsp_quat_x,
   output logic [DATA_WIDTH-1:0] rsp_quat_y,
   output logic [DATA_WIDTH-1:0] rsp_quat_z,
   output logic [1:0]            rsp_case_taken,
   output logic                  rsp_saturated
);

   localparam int W   = DATA_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int RS  = ((W > F) ? W : F) + 3;
   localparam int RU  = RS - 1;
   localparam int SI  = RU + F;
   localparam int NP  = (SI + 1) / 2;
   localparam int DVW = NP + 1;
   localparam int NW  = W + F + 2;
   localparam int OW  = NW + NP + W + 1;
   localparam int MW  = ((NP > W) ? NP : W) + 1;
   localparam int LAT = NP + W + 3;

   localparam logic signed [RS-1:0] ONE_VAL = RS'(1) << F;
   localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] NEG_MAX = {1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      case_type       sel;
      logic [2:0][W:0] num;
   } qside_type;

   typedef struct packed {
      case_type        sel;
      logic [2:0]      neg;
      logic [2:0]      ovf;
      logic            h0;
      logic [NP-1:0]   half;
   } dside_type;

   logic accept;

   logic signed [RS-1:0] trace_w;
   logic signed [RS-1:0] rad_w;
   qside_type            s1_in;

   qside_type            s1_ff;
   logic signed [RS-1:0] s1_rad_ff;
   logic                 s1_vld_ff;

   logic [RU-1:0]        rad_pos;
   logic [2*NP-1:0]      sqrt_in;
   logic [NP-1:0]        root;

   qside_type            qs_ff  [NP];
   logic [NP-1:0]        qv_ff;

   dside_type            p_in;
   logic [NW-1:0]        p_num_in [3];
   dside_type            p_ff;
   logic [NW-1:0]        p_num_ff [3];
   logic [DVW-1:0]       p_den_ff;
   logic                 p_vld_ff;

   logic [W-1:0]         quo [3];
   dside_type            ds_ff [W];
   logic [W-1:0]         dv_ff;

   logic [W-1:0]         lv [3];
   logic [2:0]           lsat;
   logic [W-1:0]         selv;
   logic                 ssat;
   logic [W-1:0]         quat_in [4];
   logic [W-1:0]         quat_ff [4];
   logic [1:0]           case_ff;
   logic                 sat_in;
   logic                 sat_ff;
   logic                 strobe_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Pick the branch, radicand and the three off-diagonal numerators
   always_comb begin
      trace_w = $signed(req_elem_r0c0) + $signed(req_elem_r1c1) + $signed(req_elem_r2c2);
      s1_in   = '0;
      priority if (trace_w > 0) begin
         s1_in.sel    = CASE_TRACE;
         rad_w        = ONE_VAL + trace_w;
         s1_in.num[0] = $signed(req_elem_r2c1) - $signed(req_elem_r1c2);
         s1_in.num[1] = $signed(req_elem_r0c2) - $signed(req_elem_r2c0);
         s1_in.num[2] = $signed(req_elem_r1c0) - $signed(req_elem_r0c1);
      end else if ($signed(req_elem_r0c0) > $signed(req_elem_r1c1) &&
                   $signed(req_elem_r0c0) > $signed(req_elem_r2c2)) begin
         s1_in.sel    = CASE_X;
         rad_w        = ONE_VAL + $signed(req_elem_r0c0) - $signed(req_elem_r1c1)
                        - $signed(req_elem_r2c2);
         s1_in.num[0] = $signed(req_elem_r2c1) - $signed(req_elem_r1c2);
         s1_in.num[1] = $signed(req_elem_r0c1) + $signed(req_elem_r1c0);
         s1_in.num[2] = $signed(req_elem_r0c2) + $signed(req_elem_r2c0);
      end else if ($signed(req_elem_r1c1) > $signed(req_elem_r2c2)) begin
         s1_in.sel    = CASE_Y;
         rad_w        = ONE_VAL + $signed(req_elem_r1c1) - $signed(req_elem_r0c0)
                        - $signed(req_elem_r2c2);
         s1_in.num[0] = $signed(req_elem_r0c2) - $signed(req_elem_r2c0);
         s1_in.num[1] = $signed(req_elem_r0c1) + $signed(req_elem_r1c0);
         s1_in.num[2] = $signed(req_elem_r1c2) + $signed(req_elem_r2c1);
      end else begin
         s1_in.sel    = CASE_Z;
         rad_w        = ONE_VAL + $signed(req_elem_r2c2) - $signed(req_elem_r0c0)
                        - $signed(req_elem_r1c1);
         s1_in.num[0] = $signed(req_elem_r1c0) - $signed(req_elem_r0c1);
         s1_in.num[1] = $signed(req_elem_r0c2) + $signed(req_elem_r2c0);
         s1_in.num[2] = $signed(req_elem_r1c2) + $signed(req_elem_r2c1);
      end
   end

   always_ff @(posedge clock) begin
      s1_ff     <= s1_in;
      s1_rad_ff <= rad_w;
   end

   // Clamp a negative radicand to zero and scale it for the root
   assign rad_pos = s1_rad_ff[RS-1] ? '0 : s1_rad_ff[RU-1:0];
   assign sqrt_in = (2*NP)'({rad_pos, {F{1'b0}}});

   rmq_isqrt #(.NP(NP)) u_isqrt (
      .clock    (clock),
      .rad_in   (sqrt_in),
      .root_out (root)
   );

   // Carry branch and numerators alongside the root
   always_ff @(posedge clock) begin
      qs_ff[0] <= s1_ff;
      for (int k = 1; k < NP; k++) begin
         qs_ff[k] <= qs_ff[k-1];
      end
   end

   // Form dividends, divisor and overflow flags
   always_comb begin
      logic [W:0]    mag;
      logic [NP:0]   hp1;
      logic [OW-1:0] lim;
      p_in      = '0;
      p_in.sel  = qs_ff[NP-1].sel;
      p_in.h0   = (root == '0);
      hp1       = {1'b0, root} + (NP+1)'(1);
      p_in.half = hp1[NP:1];
      lim       = OW'({root, 1'b0}) << W;
      for (int i = 0; i < 3; i++) begin
         p_in.neg[i] = qs_ff[NP-1].num[i][W];
         mag         = p_in.neg[i] ? (~qs_ff[NP-1].num[i] + (W+1)'(1))
                                   : qs_ff[NP-1].num[i];
         p_num_in[i] = NW'({mag, {F{1'b0}}}) + NW'(root);
         p_in.ovf[i] = OW'(p_num_in[i]) >= lim;
      end
   end

   always_ff @(posedge clock) begin
      p_ff     <= p_in;
      p_den_ff <= {root, 1'b0};
      for (int i = 0; i < 3; i++) begin
         p_num_ff[i] <= p_num_in[i];
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      rmq_div #(.NW(NW), .DVW(DVW), .QW(W)) u_div (
         .clock   (clock),
         .num_in  (p_num_ff[i]),
         .den_in  (p_den_ff),
         .quo_out (quo[i])
      );
   end

   // Carry flags alongside the quotients
   always_ff @(posedge clock) begin
      ds_ff[0] <= p_ff;
      for (int k = 1; k < W; k++) begin
         ds_ff[k] <= ds_ff[k-1];
      end
   end

   // Apply sign, saturate and place the components
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lv[i]   = '0;
         lsat[i] = 1'b0;
         if (!ds_ff[W-1].h0) begin
            if (ds_ff[W-1].ovf[i] || quo[i][W-1] &&
                (!ds_ff[W-1].neg[i] || quo[i][W-2:0] != '0)) begin
               lsat[i] = 1'b1;
               lv[i]   = ds_ff[W-1].neg[i] ? NEG_MAX : POS_MAX;
            end else begin
               lv[i] = ds_ff[W-1].neg[i] ? (~quo[i] + W'(1)) : quo[i];
            end
         end
      end
      ssat = MW'(ds_ff[W-1].half) > MW'(POS_MAX);
      selv = ssat ? POS_MAX : W'(ds_ff[W-1].half);
      unique case (ds_ff[W-1].sel)
         CASE_TRACE: begin
            quat_in[0] = selv;  quat_in[1] = lv[0];
            quat_in[2] = lv[1]; quat_in[3] = lv[2];
         end
         CASE_X: begin
            quat_in[0] = lv[0]; quat_in[1] = selv;
            quat_in[2] = lv[1]; quat_in[3] = lv[2];
         end
         CASE_Y: begin
            quat_in[0] = lv[0]; quat_in[1] = lv[1];
            quat_in[2] = selv;  quat_in[3] = lv[2];
         end
         CASE_Z: begin
            quat_in[0] = lv[0]; quat_in[1] = lv[1];
            quat_in[2] = lv[2]; quat_in[3] = selv;
         end
         default: begin
            quat_in[0] = '0; quat_in[1] = '0;
            quat_in[2] = '0; quat_in[3] = '0;
         end
      endcase
      sat_in = ds_ff[W-1].h0 || ssat || (lsat != '0);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         quat_ff[i] <= quat_in[i];
      end
      case_ff <= ds_ff[W-1].sel;
      sat_ff  <= sat_in;
   end

   // Advance the valid bits; reset drops every request in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         qv_ff     <= '0;
         p_vld_ff  <= 1'b0;
         dv_ff     <= '0;
         strobe_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
         qv_ff     <= {qv_ff[NP-2:0], s1_vld_ff};
         p_vld_ff  <= qv_ff[NP-1];
         dv_ff     <= {dv_ff[W-2:0], p_vld_ff};
         strobe_ff <= dv_ff[W-1];
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_quat_w     = quat_ff[0];
   assign rsp_quat_x     = quat_ff[1];
   assign rsp_quat_y     = quat_ff[2];
   assign rsp_quat_z     = quat_ff[3];
   assign rsp_case_taken = case_ff;
   assign rsp_saturated  = sat_ff;

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LAT))
      else $error("result without a matching request");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_strobe)
      else $error("request did not produce a result");

endmodule

// File: sim/rotation_matrix_to_quaternion_tb.sv
module rotation_matrix_to_quaternion_tb;
   import rmq_pkg::*;

   localparam int DW = 16;
   localparam int FB = 14;
   localparam int LATENCY = 40;

   typedef struct packed {
      logic [DW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
   } matrix_type;

   typedef struct packed {
      logic [DW-1:0] w, x, y, z;
      case_type      branch;
      logic          sat;
   } quat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [DW-1:0] e00 = '0, e01 = '0, e02 = '0, e10 = '0, e11 = '0;
   logic [DW-1:0] e12 = '0, e20 = '0, e21 = '0, e22 = '0;
   logic          rsp_strobe;
   logic [DW-1:0] rsp_w, rsp_x, rsp_y, rsp_z;
   logic [1:0]    rsp_case;
   logic          rsp_sat;

   matrix_type matrix_queue[$];
   quat_type   quat_queue[$];
   int      error_count = 0;
   int      accepted_count = 0;
   int      checked_count = 0;
   int      branch_seen[4] = '{0, 0, 0, 0};
   int      sat_seen = 0;
   bit      stimulus_done = 1'b0;
   int      gap_left = 0;

   always #1 clock = ~clock;

   rotation_matrix_to_quaternion #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_elem_r0c0(e00), .req_elem_r0c1(e01), .req_elem_r0c2(e02),
      .req_elem_r1c0(e10), .req_elem_r1c1(e11), .req_elem_r1c2(e12),
      .req_elem_r2c0(e20), .req_elem_r2c1(e21), .req_elem_r2c2(e22),
      .rsp_strobe(rsp_strobe), .rsp_quat_w(rsp_w), .rsp_quat_x(rsp_x),
      .rsp_quat_y(rsp_y), .rsp_quat_z(rsp_z), .rsp_case_taken(rsp_case),
      .rsp_saturated(rsp_sat)
   );

   // Integer square root, floor
   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Divide by twice the root, nearest with ties away from zero
   function automatic longint scaled_quotient(longint num, longint unsigned h);
      longint unsigned mag, q;
      mag = (num < 0) ? longint'(-num) : num;
      q = ((mag << FB) + h) / (2 * h);
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [DW-1:0] clamp_part(longint v, ref logic sat);
      longint hi, lo;
      hi = (longint'(1) << (DW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         v = hi;
         sat = 1'b1;
      end else if (v < lo) begin
         v = lo;
         sat = 1'b1;
      end
      return v[DW-1:0];
   endfunction

   // Shepperd four-case conversion
   function automatic quat_type matrix_to_quat(matrix_type m);
      longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
      longint tr, rad, v;
      longint num[4];
      longint unsigned h;
      logic [DW-1:0] part[4];
      case_type br;
      logic sat;
      quat_type q;
      a00 = longint'(signed'(m.m00)); a01 = longint'(signed'(m.m01));
      a02 = longint'(signed'(m.m02)); a10 = longint'(signed'(m.m10));
      a11 = longint'(signed'(m.m11)); a12 = longint'(signed'(m.m12));
      a20 = longint'(signed'(m.m20)); a21 = longint'(signed'(m.m21));
      a22 = longint'(signed'(m.m22));
      tr = a00 + a11 + a22;
      sat = 1'b0;
      num = '{0, 0, 0, 0};
      if (tr > 0) begin
         br = CASE_TRACE;
         rad = (longint'(1) << FB) + tr;
         num[1] = a21 - a12; num[2] = a02 - a20; num[3] = a10 - a01;
      end else if (a00 > a11 && a00 > a22) begin
         br = CASE_X;
         rad = (longint'(1) << FB) + a00 - a11 - a22;
         num[0] = a21 - a12; num[2] = a01 + a10; num[3] = a02 + a20;
      end else if (a11 > a22) begin
         br = CASE_Y;
         rad = (longint'(1) << FB) + a11 - a00 - a22;
         num[0] = a02 - a20; num[1] = a01 + a10; num[3] = a12 + a21;
      end else begin
         br = CASE_Z;
         rad = (longint'(1) << FB) + a22 - a00 - a11;
         num[0] = a10 - a01; num[1] = a02 + a20; num[2] = a12 + a21;
      end
      if (rad < 0) rad = 0;
      h = root_floor(longint'(rad) << FB);
      if (h == 0) sat = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if (i == int'(br)) v = longint'((h + 1) >> 1);
         else if (h == 0) v = 0;
         else v = scaled_quotient(num[i], h);
         part[i] = clamp_part(v, sat);
      end
      q.w = part[0]; q.x = part[1]; q.y = part[2]; q.z = part[3];
      q.branch = br;
      q.sat = sat;
      return q;
   endfunction

   task automatic report_mismatch(string field, logic [DW-1:0] got, logic [DW-1:0] want);
      error_count++;
      $display("mismatch on %s at %0t: got %h, want %h", field, $time, got, want);
   endtask

   function automatic logic [DW-1:0] rand_entry();
      case ($urandom_range(0, 5))
         0: return DW'($urandom());
         1: return 16'h4000;
         2: return 16'hC000;
         3: return 16'(signed'($urandom_range(0, 200)) - 100);
         default: return 16'(int'($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   // Rotation matrix from a random unit quaternion, with optional noise
   function automatic matrix_type rand_rotation(int noise);
      real qw, qx, qy, qz, n;
      real r[9];
      matrix_type m;
      qw = real'($urandom_range(0, 2000)) - 1000.0;
      qx = real'($urandom_range(0, 2000)) - 1000.0;
      qy = real'($urandom_range(0, 2000)) - 1000.0;
      qz = real'($urandom_range(0, 2000)) - 1000.0;
      n = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
      if (n < 1.0) begin
         qw = 1.0;
         n = 1.0;
      end
      qw /= n; qx /= n; qy /= n; qz /= n;
      r[0] = 1 - 2 * (qy * qy + qz * qz); r[1] = 2 * (qx * qy - qz * qw);
      r[2] = 2 * (qx * qz + qy * qw);     r[3] = 2 * (qx * qy + qz * qw);
      r[4] = 1 - 2 * (qx * qx + qz * qz); r[5] = 2 * (qy * qz - qx * qw);
      r[6] = 2 * (qx * qz - qy * qw);     r[7] = 2 * (qy * qz + qx * qw);
      r[8] = 1 - 2 * (qx * qx + qy * qy);
      for (int i = 0; i < 9; i++)
         r[i] = r[i] * 16384.0 + real'(int'($urandom_range(0, 2 * noise)) - noise);
      m.m00 = 16'($rtoi(r[0])); m.m01 = 16'($rtoi(r[1])); m.m02 = 16'($rtoi(r[2]));
      m.m10 = 16'($rtoi(r[3])); m.m11 = 16'($rtoi(r[4])); m.m12 = 16'($rtoi(r[5]));
      m.m20 = 16'($rtoi(r[6])); m.m21 = 16'($rtoi(r[7])); m.m22 = 16'($rtoi(r[8]));
      return m;
   endfunction

   function automatic matrix_type diag(int d0, int d1, int d2, int off);
      matrix_type m;
      m = {9{16'(off)}};
      m.m00 = 16'(d0); m.m11 = 16'(d1); m.m22 = 16'(d2);
      return m;
   endfunction

   // Fill the request queue: directed corners, then random
   initial begin
      matrix_type m;
      matrix_queue.push_back(diag(16384, 16384, 16384, 0));
      matrix_queue.push_back(diag(16384, -16384, -16384, 0));
      matrix_queue.push_back(diag(-16384, 16384, -16384, 0));
      matrix_queue.push_back(diag(-16384, -16384, 16384, 0));
      matrix_queue.push_back(diag(0, 0, 0, 0));
      matrix_queue.push_back(diag(-16384, -16384, -16384, 0));
      matrix_queue.push_back(diag(-32768, -32768, -32768, 32767));
      matrix_queue.push_back(diag(32767, 32767, 32767, -32768));
      matrix_queue.push_back(diag(32767, 32767, 32767, 32767));
      matrix_queue.push_back(diag(-32768, -32768, -32768, -32768));
      matrix_queue.push_back(diag(-16384, -16384, 0, 0));
      matrix_queue.push_back(diag(0, -1, -1, 0));
      matrix_queue.push_back(diag(1, 1, -2, 0));
      matrix_queue.push_back(diag(-16384, 0, 0, 32767));
      matrix_queue.push_back(diag(-32768, 0, 0, -32768));
      matrix_queue.push_back(diag(-8192, -8192, 16384, 32767));
      matrix_queue.push_back({9{16'hFFFF}});
      matrix_queue.push_back({9{16'h5555}});
      matrix_queue.push_back({9{16'hAAAA}});
      // Tie between m00 and m11 falls through to the z branch, with a large radicand
      matrix_queue.push_back({16'(-16384), 16'd32767, 16'(-32768), 16'(-32768),
                              16'(-16384), 16'd32767, 16'd32767, 16'(-32768), 16'd16383});
      for (int i = 0; i < 1330; i++) begin
         if ($urandom_range(0, 9) < 7) begin
            m = rand_rotation($urandom_range(0, 3) == 0 ? 200 : 2);
         end else begin
            m.m00 = rand_entry(); m.m01 = rand_entry(); m.m02 = rand_entry();
            m.m10 = rand_entry(); m.m11 = rand_entry(); m.m12 = rand_entry();
            m.m20 = rand_entry(); m.m21 = rand_entry(); m.m22 = rand_entry();
         end
         matrix_queue.push_back(m);
      end
      stimulus_done = 1'b1;
   end

   // Hold reset at the start of the run, then release it
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // Drive requests, with random gaps
   always @(posedge clock) begin
      matrix_type m;
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         start <= 1'b1;
      end else begin
         if (start) begin
            accepted_count++;
         end
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (matrix_queue.size() > 0) begin
            m = matrix_queue.pop_front();
            quat_queue.push_back(matrix_to_quat(m));
            {e00, e01, e02, e10, e11, e12, e20, e21, e22} <= m;
            start <= 1'b1;
            if ($urandom_range(0, 2) == 0)
               gap_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                                                        : $urandom_range(1, 3);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Check each result against the oldest expected quaternion
   always @(posedge clock) begin
      quat_type q;
      if (!reset && rsp_strobe) begin
         if (quat_queue.size() == 0) begin
            error_count++;
            $display("unexpected result at %0t", $time);
         end else begin
            q = quat_queue.pop_front();
            checked_count++;
            branch_seen[q.branch]++;
            if (q.sat) sat_seen++;
            if (rsp_w !== q.w) report_mismatch("quat_w", rsp_w, q.w);
            if (rsp_x !== q.x) report_mismatch("quat_x", rsp_x, q.x);
            if (rsp_y !== q.y) report_mismatch("quat_y", rsp_y, q.y);
            if (rsp_z !== q.z) report_mismatch("quat_z", rsp_z, q.z);
            if (rsp_case !== q.branch)
               report_mismatch("case_taken", DW'(rsp_case), DW'(q.branch));
            if (rsp_sat !== q.sat)
               report_mismatch("saturated", DW'(rsp_sat), DW'(q.sat));
         end
      end
   end

   // Wait for the pipeline to drain, then give the verdict
   initial begin
      wait (stimulus_done);
      while (reset || matrix_queue.size() != 0 || start) @(posedge clock);
      while (quat_queue.size() != 0) @(posedge clock);
      repeat (LATENCY * 2) @(posedge clock);
      $display("sent %0d requests, checked %0d results: trace %0d, x %0d, y %0d, z %0d",
               accepted_count, checked_count, branch_seen[0], branch_seen[1],
               branch_seen[2], branch_seen[3]);
      $display("results with the saturation flag set: %0d", sat_seen);
      if (error_count == 0 && quat_queue.size() == 0)
         $display("rotation_matrix_to_quaternion_tb passed");
      else
         $display("rotation_matrix_to_quaternion_tb failed");
      $finish;
   end

   // Hard limit on run length
   initial begin
      #1000000;
      $display("rotation_matrix_to_quaternion_tb failed");
      $finish;
   end

endmodule
